// ===== design/flow_reprojection_cost_top_defines.svh =====
// ---------------------------------------------------------------------------
// flow_reprojection_cost_top_defines.svh
// Assertion macros for the flow reprojection cost block.
// ---------------------------------------------------------------------------
`ifndef FLOW_REPROJECTION_COST_TOP_DEFINES_SVH
`define FLOW_REPROJECTION_COST_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// General property, checked out of reset.
`define FRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("flow_reprojection_cost assertion failed");
// Property that must hold whenever a result is presented.
`define FRC_ASSERT_OUT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (prop)) \
    else $error("flow_reprojection_cost result check failed");
`else
`define FRC_ASSERT(lbl, prop)
`define FRC_ASSERT_OUT(lbl, prop)
`endif
`endif

// ===== design/frc_pkg.sv =====
// ---------------------------------------------------------------------------
// frc_pkg
// Types, constants and saturating helpers for the flow reprojection cost block.
// ---------------------------------------------------------------------------
package frc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COEF_WIDTH  = 32;
  localparam int NUM_REGS    = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Latency of the arithmetic units, in register stages.
  localparam int MUL_LAT   = 5;
  localparam int DIV_STEPS = 80;            // 64-bit magnitude shifted up by 16
  localparam int DIV_LAT   = DIV_STEPS + 4;

  typedef logic signed [63:0] q64_t;

  localparam q64_t ONE_Q16     = 64'sd65536;
  localparam q64_t Q64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q64_t Q64_MIN     = 64'sh8000_0000_0000_0000;
  localparam q64_t Q32_MAX_EXT = 64'sd2147483647;
  localparam q64_t Q32_MIN_EXT = -64'sd2147483648;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B00_B01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B02_B03 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B10_B11 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B12_B13 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B20_B21 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B22_B23 = 3'd5;

  localparam logic [CFG_DATA_W-1:0] RST_B00_B01 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_B02_B03 = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_B10_B11 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] RST_B12_B13 = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_B20_B21 = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_B22_B23 = 64'h0001_0000_0000_0000;

  localparam logic [1:0] MODE_AUTO = 2'd0;
  localparam logic [1:0] MODE_U    = 2'd1;
  localparam logic [1:0] MODE_V    = 2'd2;

  localparam logic AXIS_U = 1'b0;
  localparam logic AXIS_V = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic [1:0]                    mode;
  } frc_in_t;

  typedef struct packed {
    logic signed [31:0] cost;
    logic signed [31:0] distance;
    logic               axis_used;
    logic [1:0]         status;
  } frc_out_t;

  typedef struct packed {
    logic ov;
    q64_t val;
  } satq_t;

  function automatic satq_t sat_add(input q64_t x, input q64_t y);
    logic [64:0] s;
    satq_t r;
    s = {x[63], x} + {y[63], y};
    r.ov  = s[64] ^ s[63];
    r.val = r.ov ? (s[64] ? Q64_MIN : Q64_MAX) : q64_t'(s[63:0]);
    return r;
  endfunction

  function automatic satq_t sat_sub(input q64_t x, input q64_t y);
    logic [64:0] s;
    satq_t r;
    s = {x[63], x} - {y[63], y};
    r.ov  = s[64] ^ s[63];
    r.val = r.ov ? (s[64] ? Q64_MIN : Q64_MAX) : q64_t'(s[63:0]);
    return r;
  endfunction

endpackage

// ===== design/frc_mul.sv =====
// ---------------------------------------------------------------------------
// frc_mul
// Pipelined Q16 multiplier: round(a*b/2^16), ties away, saturated to 64 bits.
// ---------------------------------------------------------------------------
module frc_mul (
  input  logic          clk,
  input  logic          en,
  input  frc_pkg::q64_t a,
  input  frc_pkg::q64_t b,
  output frc_pkg::q64_t p,
  output logic          ov
);
  import frc_pkg::*;

  logic [63:0]  xm_r, ym_r;
  logic [3:0]   neg_r;
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [64:0]  mid_r;
  logic [63:0]  ll3_r, hh3_r;
  logic [127:0] prod_r;
  logic [111:0] mag;
  logic [63:0]  lim;
  logic         sat;
  q64_t         p_nxt, p_r;
  logic         ov_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xm_r   <= a[63] ? (~a + 64'd1) : a;
      ym_r   <= b[63] ? (~b + 64'd1) : b;
      neg_r  <= {neg_r[2:0], a[63] ^ b[63]};
      ll_r   <= xm_r[31:0]  * ym_r[31:0];
      lh_r   <= xm_r[31:0]  * ym_r[63:32];
      hl_r   <= xm_r[63:32] * ym_r[31:0];
      hh_r   <= xm_r[63:32] * ym_r[63:32];
      mid_r  <= {1'b0, lh_r} + {1'b0, hl_r};
      ll3_r  <= ll_r;
      hh3_r  <= hh_r;
      // add the rounding half together with the cross terms
      prod_r <= {hh3_r, ll3_r} + {31'b0, mid_r, 32'b0} + 128'h8000;
      p_r    <= p_nxt;
      ov_r   <= sat;
    end
  end

  always_comb begin
    mag = prod_r[127:16];
    lim = neg_r[3] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    sat = (|mag[111:64]) || (mag[63:0] > lim);
    if (sat) begin
      p_nxt = neg_r[3] ? Q64_MIN : Q64_MAX;
    end else begin
      p_nxt = neg_r[3] ? q64_t'(~mag[63:0] + 64'd1) : q64_t'(mag[63:0]);
    end
  end

  assign p  = p_r;
  assign ov = ov_r;

endmodule

// ===== design/frc_div.sv =====
// ---------------------------------------------------------------------------
// frc_div
// Pipelined Q16 divider: round(n*2^16/d), one restoring step per stage.
// ---------------------------------------------------------------------------
module frc_div (
  input  logic          clk,
  input  logic          en,
  input  frc_pkg::q64_t n,
  input  frc_pkg::q64_t d,
  output frc_pkg::q64_t q,
  output logic          ov
);
  import frc_pkg::*;

  logic [63:0]          rem_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] nq_r  [DIV_STEPS+1];
  logic [63:0]          ud_r  [DIV_STEPS+1];
  logic [DIV_STEPS:0]   neg_r;

  logic [64:0]          trial_w [1:DIV_STEPS];
  logic [64:0]          diff_w  [1:DIV_STEPS];
  logic [DIV_STEPS:1]   ge_w;

  logic                 up_r, neg_a_r, neg_b_r;
  logic [DIV_STEPS-1:0] qt_r, qr_r;
  logic [63:0]          lim;
  logic                 sat;
  q64_t                 q_nxt, q_r;
  logic                 ov_r;

  always_comb begin
    for (int k = 1; k <= DIV_STEPS; k++) begin
      trial_w[k] = {rem_r[k-1], nq_r[k-1][DIV_STEPS-1]};
      diff_w[k]  = trial_w[k] - {1'b0, ud_r[k-1]};
      ge_w[k]    = trial_w[k] >= {1'b0, ud_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= {(n[63] ? (~n + 64'd1) : n), 16'b0};
      ud_r[0]  <= d[63] ? (~d + 64'd1) : d;
      neg_r[0] <= n[63] ^ d[63];
      // shift quotient bits in as dividend bits drop out
      for (int k = 1; k <= DIV_STEPS; k++) begin
        rem_r[k] <= ge_w[k] ? diff_w[k][63:0] : trial_w[k][63:0];
        nq_r[k]  <= {nq_r[k-1][DIV_STEPS-2:0], ge_w[k]};
        ud_r[k]  <= ud_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
      up_r    <= {rem_r[DIV_STEPS], 1'b0} >= {1'b0, ud_r[DIV_STEPS]};
      qt_r    <= nq_r[DIV_STEPS];
      neg_a_r <= neg_r[DIV_STEPS];
      qr_r    <= qt_r + DIV_STEPS'(up_r);
      neg_b_r <= neg_a_r;
      q_r     <= q_nxt;
      ov_r    <= sat;
    end
  end

  always_comb begin
    lim = neg_b_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    sat = (|qr_r[DIV_STEPS-1:64]) || (qr_r[63:0] > lim);
    if (sat) begin
      q_nxt = neg_b_r ? Q64_MIN : Q64_MAX;
    end else begin
      q_nxt = neg_b_r ? q64_t'(~qr_r[63:0] + 64'd1) : q64_t'(qr_r[63:0]);
    end
  end

  assign q  = q_r;
  assign ov = ov_r;

endmodule

// ===== design/flow_reprojection_cost_top.sv =====
// ---------------------------------------------------------------------------
// flow_reprojection_cost_top
// Motion-consistency residual of one optical-flow vector under a 3x4 matrix.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one flow vector (start and
//   end point in Q12.4) and a mode. Result channel out_valid/out_stall/out_data
//   returns cost, distance (d1), the axis used and a status code.
//   The six 64-bit coefficient registers are written through cfg_wr_en,
//   cfg_index and cfg_data while no item is in flight; indexes 6 and 7 are
//   ignored. Reset loads the identity matrix and empties the pipeline.
//   Throughput: one item per cycle while out_stall does not hold the pipeline.
//   The pipeline is made of two 84-stage restoring dividers (one quotient
//   bit per stage), three 5-stage multiplier rounds in series and eight
//   single pipeline registers between them.
//   Stall: when a result is presented and out_stall is high the whole pipeline
//   holds and in_stall is raised; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "flow_reprojection_cost_top_defines.svh"

module flow_reprojection_cost_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  frc_pkg::frc_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output frc_pkg::frc_out_t                   out_data,
  input  logic                                cfg_wr_en,
  input  logic [frc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [frc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import frc_pkg::*;

  localparam int PIPE_LAT = 3 * MUL_LAT + 2 * DIV_LAT + 8;
  localparam int NMUL     = 11;
  // multiplier slots
  localparam int M_B00U = 0;
  localparam int M_B01V = 1;
  localparam int M_B10U = 2;
  localparam int M_B11V = 3;
  localparam int M_B20U = 4;
  localparam int M_B21V = 5;
  localparam int M_B23U = 6;
  localparam int M_B23V = 7;
  localparam int M_SWA  = 8;
  localparam int M_DSW  = 9;
  localparam int M_PD   = 10;

  typedef struct packed {
    logic axis;
    logic deg;
    logic ov;
    q64_t u1;
    q64_t v1;
    q64_t a;
    q64_t r;
    q64_t s;
    q64_t p;
    q64_t sw;
    q64_t num;
    q64_t den;
    q64_t dep;
    q64_t res;
  } ctx_t;

  typedef struct packed {
    logic               ov;
    logic signed [31:0] val;
  } sat32_t;

  function automatic q64_t coef_half(input logic [31:0] h);
    return {{(64-COEF_WIDTH){h[COEF_WIDTH-1]}}, h[COEF_WIDTH-1:0]};
  endfunction

  function automatic q64_t to_q16(input logic signed [COORD_WIDTH-1:0] x);
    return {{(52-COORD_WIDTH){x[COORD_WIDTH-1]}}, x, 12'b0};
  endfunction

  function automatic sat32_t clamp32(input q64_t x);
    sat32_t r;
    r.ov = 1'b0;
    if (x > Q32_MAX_EXT) begin
      r.ov  = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (x < Q32_MIN_EXT) begin
      r.ov  = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.val = x[31:0];
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [CFG_DATA_W-1:0] c01_r, c23_r, c1011_r, c1213_r, c2021_r, c2223_r;
  q64_t b00, b01, b02, b03, b10, b11, b12, b13, b20, b21, b22, b23;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c01_r   <= RST_B00_B01;
      c23_r   <= RST_B02_B03;
      c1011_r <= RST_B10_B11;
      c1213_r <= RST_B12_B13;
      c2021_r <= RST_B20_B21;
      c2223_r <= RST_B22_B23;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_B00_B01: c01_r   <= cfg_data;
        REG_B02_B03: c23_r   <= cfg_data;
        REG_B10_B11: c1011_r <= cfg_data;
        REG_B12_B13: c1213_r <= cfg_data;
        REG_B20_B21: c2021_r <= cfg_data;
        REG_B22_B23: c2223_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign b00 = coef_half(c01_r[63:32]);
  assign b01 = coef_half(c01_r[31:0]);
  assign b02 = coef_half(c23_r[63:32]);
  assign b03 = coef_half(c23_r[31:0]);
  assign b10 = coef_half(c1011_r[63:32]);
  assign b11 = coef_half(c1011_r[31:0]);
  assign b12 = coef_half(c1213_r[63:32]);
  assign b13 = coef_half(c1213_r[31:0]);
  assign b20 = coef_half(c2021_r[63:32]);
  assign b21 = coef_half(c2021_r[31:0]);
  assign b22 = coef_half(c2223_r[63:32]);
  assign b23 = coef_half(c2223_r[31:0]);

  // ---------------- pipeline control ----------------
  logic [PIPE_LAT-1:0] vld_r;
  logic                en;

  assign en       = !(vld_r[PIPE_LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // ---------------- arithmetic units ----------------
  q64_t             mul_a [NMUL];
  q64_t             mul_b [NMUL];
  q64_t             mul_p [NMUL];
  logic [NMUL-1:0]  mul_ov;
  q64_t             div0_q, div1_q;
  logic             div0_ov, div1_ov;

  for (genvar g = 0; g < NMUL; g++) begin : g_mul
    frc_mul u_mul (
      .clk (clk),
      .en  (en),
      .a   (mul_a[g]),
      .b   (mul_b[g]),
      .p   (mul_p[g]),
      .ov  (mul_ov[g])
    );
  end

  // ---------------- input stage ----------------
  logic signed [COORD_WIDTH:0] dx, dy;
  logic [COORD_WIDTH:0]        adx, ady;
  logic                        axis_in;
  q64_t                        u0, v0;
  ctx_t                        c_in;

  always_comb begin
    dx  = {in_data.end_x[COORD_WIDTH-1], in_data.end_x}
        - {in_data.start_x[COORD_WIDTH-1], in_data.start_x};
    dy  = {in_data.end_y[COORD_WIDTH-1], in_data.end_y}
        - {in_data.start_y[COORD_WIDTH-1], in_data.start_y};
    adx = dx[COORD_WIDTH] ? (~dx + 1'b1) : dx;
    ady = dy[COORD_WIDTH] ? (~dy + 1'b1) : dy;
    unique case (in_data.mode)
      MODE_U:  axis_in = AXIS_U;
      MODE_V:  axis_in = AXIS_V;
      default: axis_in = (ady > adx) ? AXIS_V : AXIS_U;
    endcase
    u0      = to_q16(in_data.start_x);
    v0      = to_q16(in_data.start_y);
    c_in    = '0;
    c_in.axis = axis_in;
    c_in.u1   = to_q16(in_data.end_x);
    c_in.v1   = to_q16(in_data.end_y);
  end

  ctx_t dl1_r [MUL_LAT];
  ctx_t c1;
  assign c1 = dl1_r[MUL_LAT-1];

  // ---------------- row sums and first numerator ----------------
  ctx_t  s1_r, s1_nxt, s2_r, s2_nxt;
  q64_t  t0_r, t1_r, t2_r;
  satq_t t0, t1, t2, num0, su, sv, sw;

  always_comb begin
    t0   = sat_add(mul_p[M_B00U], mul_p[M_B01V]);
    t1   = sat_add(mul_p[M_B10U], mul_p[M_B11V]);
    t2   = sat_add(mul_p[M_B20U], mul_p[M_B21V]);
    num0 = sat_sub(c1.axis ? b13 : b03, c1.axis ? mul_p[M_B23V] : mul_p[M_B23U]);
    s1_nxt     = c1;
    s1_nxt.a   = c1.axis ? c1.v1 : c1.u1;
    s1_nxt.r   = c1.axis ? c1.u1 : c1.v1;
    s1_nxt.num = num0.val;
    s1_nxt.ov  = c1.ov | (|mul_ov[M_B23V:M_B00U]) | t0.ov | t1.ov | t2.ov | num0.ov;

    su = sat_add(t0_r, b02);
    sv = sat_add(t1_r, b12);
    sw = sat_add(t2_r, b22);
    s2_nxt    = s1_r;
    s2_nxt.s  = s1_r.axis ? sv.val : su.val;
    s2_nxt.p  = s1_r.axis ? su.val : sv.val;
    s2_nxt.sw = sw.val;
    s2_nxt.ov = s1_r.ov | su.ov | sv.ov | sw.ov;
  end

  ctx_t dl2_r [MUL_LAT];
  ctx_t c2;
  assign c2 = dl2_r[MUL_LAT-1];

  // ---------------- denominator ----------------
  ctx_t  s3_r, s3_nxt, c3_in;
  satq_t den;

  always_comb begin
    den        = sat_sub(mul_p[M_SWA], c2.s);
    s3_nxt     = c2;
    s3_nxt.den = den.val;
    s3_nxt.ov  = c2.ov | mul_ov[M_SWA] | den.ov;
    c3_in      = s3_r;
    c3_in.deg  = (s3_r.den == '0);
  end

  frc_div u_div0 (
    .clk (clk),
    .en  (en),
    .n   (s3_r.num),
    .d   (s3_r.den),
    .q   (div0_q),
    .ov  (div0_ov)
  );

  ctx_t dl3_r [DIV_LAT];
  ctx_t c3;
  assign c3 = dl3_r[DIV_LAT-1];

  // ---------------- depth d0, then d1 and second numerator ----------------
  ctx_t  s4_r, s4_nxt, s5_r, s5_nxt, s6_r, s6_nxt;
  satq_t d1raw, num1;

  always_comb begin
    s4_nxt     = c3;
    s4_nxt.dep = (div0_q == '0) ? ONE_Q16 : div0_q;
    s4_nxt.ov  = c3.ov | div0_ov;
  end

  ctx_t dl4_r [MUL_LAT];
  ctx_t c4;
  assign c4 = dl4_r[MUL_LAT-1];

  always_comb begin
    d1raw      = sat_add(mul_p[M_DSW], b23);
    num1       = sat_add(mul_p[M_PD], c4.axis ? b03 : b13);
    s5_nxt     = c4;
    s5_nxt.dep = d1raw.val;
    s5_nxt.num = num1.val;
    s5_nxt.ov  = c4.ov | mul_ov[M_DSW] | mul_ov[M_PD] | d1raw.ov | num1.ov;
    s6_nxt     = s5_r;
    s6_nxt.dep = (s5_r.dep == '0) ? ONE_Q16 : s5_r.dep;
  end

  frc_div u_div1 (
    .clk (clk),
    .en  (en),
    .n   (s6_r.num),
    .d   (s6_r.dep),
    .q   (div1_q),
    .ov  (div1_ov)
  );

  ctx_t dl5_r [DIV_LAT];
  ctx_t c5;
  assign c5 = dl5_r[DIV_LAT-1];

  // ---------------- residual and output ----------------
  ctx_t     s7_r, s7_nxt;
  satq_t    resid;
  sat32_t   cost32, dist32;
  frc_out_t out_r, out_nxt;

  always_comb begin
    resid      = sat_sub(c5.r, div1_q);
    s7_nxt     = c5;
    s7_nxt.res = resid.val;
    s7_nxt.ov  = c5.ov | div1_ov | resid.ov;

    cost32 = clamp32(s7_r.res);
    dist32 = clamp32(s7_r.dep);
    out_nxt.axis_used = s7_r.axis;
    if (s7_r.deg) begin
      out_nxt.cost     = '0;
      out_nxt.distance = '0;
      out_nxt.status   = STATUS_DEGEN;
    end else begin
      out_nxt.cost     = cost32.val;
      out_nxt.distance = dist32.val;
      out_nxt.status   = (s7_r.ov | cost32.ov | dist32.ov) ? STATUS_SAT : STATUS_OK;
    end
  end

  // ---------------- multiplier operands ----------------
  always_comb begin
    mul_a[M_B00U] = b00;  mul_b[M_B00U] = u0;
    mul_a[M_B01V] = b01;  mul_b[M_B01V] = v0;
    mul_a[M_B10U] = b10;  mul_b[M_B10U] = u0;
    mul_a[M_B11V] = b11;  mul_b[M_B11V] = v0;
    mul_a[M_B20U] = b20;  mul_b[M_B20U] = u0;
    mul_a[M_B21V] = b21;  mul_b[M_B21V] = v0;
    mul_a[M_B23U] = b23;  mul_b[M_B23U] = c_in.u1;
    mul_a[M_B23V] = b23;  mul_b[M_B23V] = c_in.v1;
    mul_a[M_SWA]  = s2_r.sw;
    mul_b[M_SWA]  = s2_r.a;
    mul_a[M_DSW]  = s4_r.dep;
    mul_b[M_DSW]  = s4_r.sw;
    mul_a[M_PD]   = s4_r.p;
    mul_b[M_PD]   = s4_r.dep;
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      dl1_r[0] <= c_in;
      for (int i = 1; i < MUL_LAT; i++) dl1_r[i] <= dl1_r[i-1];
      s1_r <= s1_nxt;
      t0_r <= t0.val;
      t1_r <= t1.val;
      t2_r <= t2.val;
      s2_r <= s2_nxt;
      dl2_r[0] <= s2_r;
      for (int i = 1; i < MUL_LAT; i++) dl2_r[i] <= dl2_r[i-1];
      s3_r <= s3_nxt;
      dl3_r[0] <= c3_in;
      for (int i = 1; i < DIV_LAT; i++) dl3_r[i] <= dl3_r[i-1];
      s4_r <= s4_nxt;
      dl4_r[0] <= s4_r;
      for (int i = 1; i < MUL_LAT; i++) dl4_r[i] <= dl4_r[i-1];
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      dl5_r[0] <= s6_r;
      for (int i = 1; i < DIV_LAT; i++) dl5_r[i] <= dl5_r[i-1];
      s7_r  <= s7_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_data  = out_r;

  // ---------------- assertions ----------------
  `FRC_ASSERT(a_hold_on_stall, !en |=> $stable(vld_r) && $stable(out_r))
  `FRC_ASSERT_OUT(a_degen_zero, (out_data.status != STATUS_DEGEN) || (out_data.cost == '0 && out_data.distance == '0))
  `FRC_ASSERT_OUT(a_depth_nonzero, (out_data.status == STATUS_DEGEN) || (out_data.distance != '0))
  `FRC_ASSERT_OUT(a_status_code, out_data.status == STATUS_OK || out_data.status == STATUS_DEGEN || out_data.status == STATUS_SAT)

endmodule
